// ===== hw/rtl/cvs_pkg.sv =====
// ----------------------------------------------------------------------------
// Composite video sync generator package
// Shared constants, types and the vertical segment table.
// ----------------------------------------------------------------------------
`default_nettype none

package cvs_pkg;

  // Widths of the timer, the picture row counter and the line counter.
  localparam int CounterBits   = 8;
  localparam int RowBits       = 8;
  localparam int LineBits      = 10;
  localparam int VsyncSegments = 19;
  localparam int SegBits       = $clog2(VsyncSegments + 1);

  // Configuration port shape.
  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = 10;

  // Reset values of the configuration registers.
  localparam logic [CounterBits-1:0] TimerBaseReset  = 8'd96;
  localparam logic [LineBits-1:0]    FrameLinesReset = 10'd625;

  // Offsets from the timer base that bound the horizontal sync pulse.
  localparam logic [CounterBits:0] PreSyncOffset = 9'd3;
  localparam logic [CounterBits:0] SyncEndOffset = 9'd19;

  // Configuration register indexes.
  typedef enum logic [CfgIdxBits-1:0] {
    CFG_VIDEO_ENABLE = 2'd0,
    CFG_TIMER_BASE   = 2'd1,
    CFG_FRAME_LINES  = 2'd2
  } cfg_idx_e;

  // Phase of the current line or segment, one-hot.
  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_FIRST  = 3'b010,
    PH_SECOND = 3'b100
  } phase_e;

  typedef struct packed {
    logic                   video_enable;
    logic [CounterBits-1:0] timer_base;
    logic [LineBits-1:0]    frame_lines;
  } cfg_t;

  typedef struct packed {
    logic                   sync_level;
    logic                   luma_blank;
    logic [7:0]             picture_row;
    logic                   in_vertical;
    logic                   frame_done;
  } res_t;

  // One segment of the vertical interval.
  typedef struct packed {
    logic                   keep_timer;
    logic                   has_low;
    logic [CounterBits-1:0] reload;
    logic [CounterBits-1:0] low_until;
    logic [CounterBits-1:0] high_until;
  } seg_row_t;

  // Vertical segment table, indexed from one.
  function automatic seg_row_t seg_rom(input logic [SegBits-1:0] n);
    seg_row_t r;
    case (n)
      5'd1, 5'd13:                     r = '{1'b0, 1'b1, 8'd65, 8'd72, 8'd145};
      5'd2, 5'd3, 5'd4, 5'd5, 5'd6,
      5'd14, 5'd15, 5'd16:             r = '{1'b0, 1'b1, 8'd0, 8'd5, 8'd79};
      5'd7, 5'd8, 5'd9, 5'd10, 5'd11,
      5'd12:                           r = '{1'b0, 1'b1, 8'd0, 8'd72, 8'd83};
      5'd17:                           r = '{1'b0, 1'b1, 8'd0, 8'd5, 8'd89};
      5'd18:                           r = '{1'b0, 1'b1, 8'd150, 8'd165, 8'd165};
      5'd19:                           r = '{1'b1, 1'b0, 8'd0, 8'd0, 8'd236};
      default:                         r = '{1'b1, 1'b0, 8'd0, 8'd0, 8'd255};
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cvs_in_if.sv =====
// ----------------------------------------------------------------------------
// Tick input channel
// Valid/ready channel that carries one timer tick per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface cvs_in_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cvs_out_if.sv =====
// ----------------------------------------------------------------------------
// Sync result channel
// Valid/ready channel that carries the sync outputs of one tick per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface cvs_out_if;
  logic       valid;
  logic       ready;
  logic       sync_level;
  logic       luma_blank;
  logic [7:0] picture_row;
  logic       in_vertical;
  logic       frame_done;

  modport source (output valid, output sync_level, output luma_blank,
                  output picture_row, output in_vertical, output frame_done,
                  input ready);
  modport sink   (input valid, input sync_level, input luma_blank,
                  input picture_row, input in_vertical, input frame_done,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cvs_cfg.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Holds video enable, timer base and frame line count.
// ----------------------------------------------------------------------------
`default_nettype none

module cvs_cfg
  import cvs_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  wire logic [CfgDataBits-1:0] cfg_wdata_i,
  output cfg_t                        cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the register index; unused indexes are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_VIDEO_ENABLE: cfg_d.video_enable = cfg_wdata_i[0];
        CFG_TIMER_BASE:   cfg_d.timer_base   = cfg_wdata_i[CounterBits-1:0];
        CFG_FRAME_LINES:  cfg_d.frame_lines  = cfg_wdata_i[LineBits-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{1'b0, TimerBaseReset, FrameLinesReset};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hw/rtl/cvs_core.sv =====
// ----------------------------------------------------------------------------
// Sync sequencer core
// Timer, line and row counters and the vertical segment player, advanced
// by one tick per step.
// ----------------------------------------------------------------------------
`default_nettype none

module cvs_core
  import cvs_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic step_i,
  input  wire logic tick_i,
  input  cfg_t      cfg_i,
  output res_t      res_o
);

  logic [CounterBits-1:0] timer_q, timer_d, timer_inc;
  logic [LineBits-1:0]    line_q, line_d, line_inc;
  logic [RowBits-1:0]     row_q, row_d;
  logic                   toggle_q, toggle_d;
  logic [SegBits-1:0]     seg_q, seg_d, enter_n;
  phase_e                 phase_q, phase_d, phase_mid;
  logic                   sync_q, sync_d;
  logic                   luma, done, enter;
  seg_row_t               cur_row, new_row;
  logic [CounterBits:0]   base_ext;

  assign timer_inc = timer_q + 1'b1;
  assign line_inc  = line_q + 1'b1;
  assign base_ext  = {1'b0, cfg_i.timer_base};
  assign cur_row   = seg_rom(seg_q);
  assign new_row   = seg_rom(enter_n);

  // Next state for one tick.
  always_comb begin
    timer_d   = timer_q;
    line_d    = line_q;
    row_d     = row_q;
    toggle_d  = toggle_q;
    seg_d     = seg_q;
    phase_d   = phase_q;
    phase_mid = phase_q;
    sync_d    = sync_q;
    luma      = 1'b0;
    done      = 1'b0;
    enter     = 1'b0;
    enter_n   = '0;
    if (tick_i) begin
      timer_d = timer_inc;
      if (seg_q != '0) begin
        // Vertical interval: low part, then high part, then next segment.
        if (seg_q > SegBits'(VsyncSegments)) begin
          seg_d   = '0;
          phase_d = PH_IDLE;
        end else begin
          if (phase_q == PH_FIRST && timer_inc > cur_row.low_until) begin
            sync_d    = 1'b1;
            phase_mid = PH_SECOND;
            phase_d   = PH_SECOND;
          end
          if (phase_mid == PH_SECOND && timer_inc > cur_row.high_until) begin
            if (seg_q >= SegBits'(VsyncSegments)) begin
              seg_d   = '0;
              phase_d = PH_IDLE;
            end else begin
              enter   = 1'b1;
              enter_n = seg_q + 1'b1;
            end
          end
        end
      end else if ((&timer_q) && cfg_i.video_enable) begin
        // Line event on timer overflow.
        timer_d = cfg_i.timer_base;
        luma    = 1'b1;
        phase_d = PH_FIRST;
      end else if (phase_q == PH_FIRST && {1'b0, timer_inc} > base_ext + PreSyncOffset) begin
        // Count the line and decide between a sync pulse and the vertical interval.
        line_d = line_inc;
        if (line_q != cfg_i.frame_lines && line_inc != (cfg_i.frame_lines >> 1)) begin
          sync_d  = 1'b0;
          phase_d = PH_SECOND;
        end else begin
          enter   = 1'b1;
          enter_n = SegBits'(1);
        end
      end else if (phase_q == PH_SECOND && {1'b0, timer_inc} > base_ext + SyncEndOffset) begin
        // End of the horizontal pulse; the row advances every second line.
        sync_d   = 1'b1;
        phase_d  = PH_IDLE;
        toggle_d = ~toggle_q;
        if (toggle_q) begin
          row_d = row_q + 1'b1;
        end
      end

      // Start a vertical segment.
      if (enter) begin
        seg_d = enter_n;
        if (!new_row.keep_timer) begin
          timer_d = new_row.reload;
        end
        phase_d = new_row.has_low ? PH_FIRST : PH_SECOND;
        sync_d  = ~new_row.has_low;
        if (enter_n == SegBits'(VsyncSegments)) begin
          line_d = '0;
          row_d  = '0;
          done   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_q  <= '0;
      line_q   <= '0;
      row_q    <= '0;
      toggle_q <= 1'b0;
      seg_q    <= '0;
      phase_q  <= PH_IDLE;
      sync_q   <= 1'b1;
    end else if (step_i) begin
      timer_q  <= timer_d;
      line_q   <= line_d;
      row_q    <= row_d;
      toggle_q <= toggle_d;
      seg_q    <= seg_d;
      phase_q  <= phase_d;
      sync_q   <= sync_d;
    end
  end

  // Result of this step, taken from the updated state.
  assign res_o.sync_level  = sync_d;
  assign res_o.luma_blank  = luma;
  assign res_o.picture_row = 8'(row_d);
  assign res_o.in_vertical = (seg_d != '0);
  assign res_o.frame_done  = done;

endmodule

`default_nettype wire

// ===== hw/rtl/composite_video_sync_generator.sv =====
// ----------------------------------------------------------------------------
// Composite video sync generator
// Each transfer on in_i carries one tick of the pixel timebase; each tick
// gives one transfer on out_o with the sync level, the luminance blank
// strobe, the picture row, the vertical interval flag and the frame end
// strobe. A tick of zero leaves all state as it is and reports it again.
// The registers (video enable, timer base, frame lines) are written through
// cfg_we_i, cfg_idx_i and cfg_wdata_i; the user must write them only while no
// transfer is outstanding, as the block itself does not enforce it.
// A tick passes through the input register, then through the sequencer into
// the result register. Throughput is one tick per cycle while the receiver
// does not stall; the timer, counters and segment state update per tick.
// When the receiver stalls, the result register holds its item and the
// input register takes one more tick; after that in_i.ready falls.
// Reset clears the counters, sets sync high, idles the vertical player and
// loads the register reset values; no transfers are pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module composite_video_sync_generator
  import cvs_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  cvs_in_if.sink                      in_i,
  cvs_out_if.source                   out_o,
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  wire logic [CfgDataBits-1:0] cfg_wdata_i
);

  cfg_t cfg;
  res_t res, res_q;
  logic in_valid_q, in_tick_q, out_valid_q, advance;

  cvs_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The held tick moves into the result register when that register is free.
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  cvs_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .tick_i (in_tick_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_tick_q <= in_i.tick;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.sync_level  = res_q.sync_level;
  assign out_o.luma_blank  = res_q.luma_blank;
  assign out_o.picture_row = res_q.picture_row;
  assign out_o.in_vertical = res_q.in_vertical;
  assign out_o.frame_done  = res_q.frame_done;

endmodule

`default_nettype wire

// ===== hw/rtl/cvs_checker.sv =====
// ----------------------------------------------------------------------------
// Sync generator port checker
// Checks the result channel of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module cvs_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       sync_level_i,
  input wire logic       luma_blank_i,
  input wire logic [7:0] picture_row_i,
  input wire logic       in_vertical_i,
  input wire logic       frame_done_i
);

  // A stalled result keeps its payload until the transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(sync_level_i) &&
      $stable(luma_blank_i) && $stable(picture_row_i) &&
      $stable(in_vertical_i) && $stable(frame_done_i))
    else $error("stalled result changed");

  // The last segment starts inside the vertical interval with sync high.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_done_i |-> in_vertical_i && sync_level_i)
    else $error("frame end outside the vertical interval or with sync low");

  // The frame end clears the picture row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_done_i |-> picture_row_i == 8'd0)
    else $error("picture row not cleared at frame end");

  // A line event never happens inside the vertical interval.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && luma_blank_i |-> !in_vertical_i && !frame_done_i)
    else $error("luminance blank during the vertical interval");

endmodule

bind composite_video_sync_generator cvs_checker u_cvs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .sync_level_i  (out_o.sync_level),
  .luma_blank_i  (out_o.luma_blank),
  .picture_row_i (out_o.picture_row),
  .in_vertical_i (out_o.in_vertical),
  .frame_done_i  (out_o.frame_done)
);

`default_nettype wire

// ===== dv/composite_video_sync_generator_tb.sv =====
// ----------------------------------------------------------------------------
// Composite video sync generator testbench
// Drives timer ticks through the input channel under a range of register
// settings, predicts every sync result in a scoreboard and checks each
// result transfer against it, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module composite_video_sync_generator_tb;
  import cvs_pkg::*;

  localparam int CycleLimit = 500000;
  localparam int LongHold   = 300;
  localparam int DrainWait  = 8;

  // Scoreboard: keeps its own copy of the sync generator state and the
  // expected sync results, oldest first.
  class vsync_scoreboard;
    typedef struct {
      logic                   keep_timer;
      logic                   has_low;
      logic [CounterBits-1:0] reload;
      logic [CounterBits-1:0] low_until;
      logic [CounterBits-1:0] high_until;
    } vseg_t;

    logic                   video_en;
    logic [CounterBits-1:0] base;
    logic [LineBits-1:0]    frame_lines;
    logic [CounterBits-1:0] timer;
    logic [LineBits-1:0]    lines;
    logic [RowBits-1:0]     row;
    logic                   pair;
    logic [SegBits-1:0]     seg;
    phase_e                 phase;
    logic                   sync;
    res_t                   sync_expected[$];
    int                     errors;

    function new();
      video_en    = 1'b0;
      base        = TimerBaseReset;
      frame_lines = FrameLinesReset;
      timer       = '0;
      lines       = '0;
      row         = '0;
      pair        = 1'b0;
      seg         = '0;
      phase       = PH_IDLE;
      sync        = 1'b1;
      errors      = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgDataBits-1:0] v);
      case (idx)
        CFG_VIDEO_ENABLE: video_en = v[0];
        CFG_TIMER_BASE:   base = v[CounterBits-1:0];
        CFG_FRAME_LINES:  frame_lines = v[LineBits-1:0];
        default: ;
      endcase
    endfunction

    // Timings of the vertical interval, one row per segment.
    function vseg_t vseg_row(logic [SegBits-1:0] n);
      vseg_t s;
      s = '{1'b0, 1'b1, 8'd0, 8'd5, 8'd79};
      case (n)
        5'd1, 5'd13:                      s = '{1'b0, 1'b1, 8'd65, 8'd72, 8'd145};
        5'd7, 5'd8, 5'd9, 5'd10, 5'd11,
        5'd12:                            s.high_until = 8'd83;
        5'd17:                            s.high_until = 8'd89;
        5'd18:                            s = '{1'b0, 1'b1, 8'd150, 8'd165, 8'd165};
        5'd19:                            s = '{1'b1, 1'b0, 8'd0, 8'd0, 8'd236};
        default: ;
      endcase
      if (n inside {5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12}) s.low_until = 8'd72;
      return s;
    endfunction

    // Starts segment n; the last one clears the line and row counters and ends the frame.
    function logic start_segment(logic [SegBits-1:0] n);
      vseg_t s;
      s   = vseg_row(n);
      seg = n;
      if (!s.keep_timer) timer = s.reload;
      if (s.has_low) begin
        phase = PH_FIRST;
        sync  = 1'b0;
      end else begin
        phase = PH_SECOND;
        sync  = 1'b1;
      end
      if (n == VsyncSegments) begin
        lines = '0;
        row   = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // Advances the model by one accepted tick and queues the sync result.
    function void note_tick(logic t);
      res_t                r;
      logic                wrapped;
      logic [LineBits-1:0] prev;
      vseg_t               s;
      r.luma_blank = 1'b0;
      r.frame_done = 1'b0;
      if (t) begin
        wrapped = (timer == '1);
        timer   = timer + 1'b1;
        if (seg != 0) begin
          if (seg > VsyncSegments) begin
            seg   = '0;
            phase = PH_IDLE;
          end else begin
            s = vseg_row(seg);
            if (phase == PH_FIRST && timer > s.low_until) begin
              sync  = 1'b1;
              phase = PH_SECOND;
            end
            if (phase == PH_SECOND && timer > s.high_until) begin
              if (seg >= VsyncSegments) begin
                seg   = '0;
                phase = PH_IDLE;
              end else begin
                r.frame_done = start_segment(seg + 1'b1);
              end
            end
          end
        end else if (wrapped && video_en) begin
          timer        = base;
          r.luma_blank = 1'b1;
          phase        = PH_FIRST;
        end else if (phase == PH_FIRST && {1'b0, timer} > {1'b0, base} + PreSyncOffset) begin
          prev  = lines;
          lines = lines + 1'b1;
          if (prev != frame_lines && lines != (frame_lines >> 1)) begin
            sync  = 1'b0;
            phase = PH_SECOND;
          end else begin
            r.frame_done = start_segment(5'd1);
          end
        end else if (phase == PH_SECOND && {1'b0, timer} > {1'b0, base} + SyncEndOffset) begin
          sync  = 1'b1;
          phase = PH_IDLE;
          if (pair) begin
            pair = 1'b0;
            row  = row + 1'b1;
          end else begin
            pair = 1'b1;
          end
        end
      end
      r.sync_level  = sync;
      r.picture_row = row;
      r.in_vertical = (seg != 0);
      sync_expected.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (sync_expected.size() == 0) begin
        $error("sync result with no tick outstanding");
        errors++;
        return;
      end
      want = sync_expected.pop_front();
      if (got.sync_level !== want.sync_level) begin
        $error("sync_level: expected %0d, got %0d", want.sync_level, got.sync_level);
        errors++;
      end
      if (got.luma_blank !== want.luma_blank) begin
        $error("luma_blank: expected %0d, got %0d", want.luma_blank, got.luma_blank);
        errors++;
      end
      if (got.picture_row !== want.picture_row) begin
        $error("picture_row: expected %0d, got %0d", want.picture_row, got.picture_row);
        errors++;
      end
      if (got.in_vertical !== want.in_vertical) begin
        $error("in_vertical: expected %0d, got %0d", want.in_vertical, got.in_vertical);
        errors++;
      end
      if (got.frame_done !== want.frame_done) begin
        $error("frame_done: expected %0d, got %0d", want.frame_done, got.frame_done);
        errors++;
      end
    endfunction

    function int pending();
      return sync_expected.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CfgIdxBits-1:0]  cfg_idx;
  logic [CfgDataBits-1:0] cfg_wdata;
  logic                   idling;
  logic                   hold_off_req;
  int                     cycle_count;

  cvs_in_if  tick_ch ();
  cvs_out_if sync_ch ();

  vsync_scoreboard sb = new();

  composite_video_sync_generator i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_i        (tick_ch),
    .out_o       (sync_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Clock.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Overall cycle limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: random stall bursts, one long hold-off on request.
  initial begin
    int   stall_left;
    int   hold_left;
    logic hold_taken;
    res_t got;
    stall_left    = 0;
    hold_left     = 0;
    hold_taken    = 1'b0;
    sync_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && sync_ch.valid && sync_ch.ready) begin
        got.sync_level  = sync_ch.sync_level;
        got.luma_blank  = sync_ch.luma_blank;
        got.picture_row = sync_ch.picture_row;
        got.in_vertical = sync_ch.in_vertical;
        got.frame_done  = sync_ch.frame_done;
        sb.check_result(got);
      end
      if (hold_off_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        sync_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        sync_ch.ready <= 1'b0;
      end else if (idling && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        sync_ch.ready <= 1'b0;
      end else begin
        sync_ch.ready <= 1'b1;
      end
    end
  end

  // Offers one tick and waits for its transfer.
  task automatic drive_tick(input logic t);
    tick_ch.valid <= 1'b1;
    tick_ch.tick  <= t;
    do @(posedge clk); while (!tick_ch.ready);
    sb.note_tick(t);
  endtask

  // Stops offering ticks and waits until every result has come back.
  task automatic drain();
    tick_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_idx_e idx, input logic [CfgDataBits-1:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  // Writes all three registers while the block is idle.
  task automatic configure(input logic en, input logic [CounterBits-1:0] tb,
                           input logic [LineBits-1:0] fl);
    drain();
    put_reg(CFG_VIDEO_ENABLE, {{(CfgDataBits-1){1'b0}}, en});
    put_reg(CFG_TIMER_BASE, {{(CfgDataBits-CounterBits){1'b0}}, tb});
    put_reg(CFG_FRAME_LINES, fl);
    cfg_we <= 1'b0;
  endtask

  // Mostly advancing ticks with an occasional held tick.
  task automatic drive_ticks(input int count, input logic gappy);
    idling <= gappy;
    repeat (count) begin
      drive_tick($urandom_range(0, 31) != 0);
      if (gappy && $urandom_range(0, 7) == 0) begin
        tick_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  endtask

  // One phase under a fresh set of register values.
  task automatic run_phase(input logic en, input logic [CounterBits-1:0] tb,
                           input logic [LineBits-1:0] fl, input int count,
                           input logic gappy);
    configure(en, tb, fl);
    drive_ticks(count, gappy);
  endtask

  // Stimulus.
  initial begin
    logic [CounterBits-1:0] tb;
    logic [LineBits-1:0]    fl;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_VIDEO_ENABLE;
    cfg_wdata    = '0;
    tick_ch.valid = 1'b0;
    tick_ch.tick  = 1'b0;
    idling       = 1'b0;
    hold_off_req = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: held and advancing ticks at the register extremes,
    // with video disabled and then enabled.
    configure(1'b0, 8'd255, 10'd1023);
    repeat (4) begin
      drive_tick(1'b0);
      drive_tick(1'b1);
    end
    drive_tick(1'b0);
    drive_tick(1'b1);
    configure(1'b1, 8'd0, 10'd0);
    repeat (4) drive_tick(1'b0);
    repeat (6) drive_tick(1'b1);

    // A full frame: short lines and a vertical interval after the first line.
    run_phase(1'b1, 8'd224, 10'd2, 1800, 1'b1);

    // Overflow before the sync pulse ends; the receiver holds off while
    // ticks keep coming.
    configure(1'b1, 8'd240, 10'd1023);
    hold_off_req <= 1'b1;
    drive_ticks(100, 1'b1);

    // Base at the top: every tick after a line event overflows again.
    run_phase(1'b1, 8'd255, 10'd1, 40, 1'b1);

    // Video disabled: the timer free-runs, a started line completes.
    run_phase(1'b0, 8'd0, 10'd0, 60, 1'b0);

    // Longest line period.
    run_phase(1'b1, 8'd0, 10'd0, 100, 1'b1);

    // Random settings, mostly short lines and small frames.
    repeat (4) begin
      tb = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                         : 8'($urandom_range(192, 255));
      fl = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                         : 10'($urandom_range(0, 8));
      run_phase($urandom_range(0, 5) != 0, tb, fl, 30, $urandom_range(0, 1) != 0);
    end

    // Closing stretch at full rate.
    run_phase(1'b1, 8'd224, 10'd2, 60, 1'b0);

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/cvs_pkg.sv
hw/rtl/cvs_in_if.sv
hw/rtl/cvs_out_if.sv
hw/rtl/cvs_cfg.sv
hw/rtl/cvs_core.sv
hw/rtl/composite_video_sync_generator.sv
hw/rtl/cvs_checker.sv
dv/composite_video_sync_generator_tb.sv
